// ===== design/salts_pkg.sv =====
// ---------------------------------------------------------------------------
// salts_pkg: shared types for the lru tag store
// controller states and the command / status structs that join the two halves
// ---------------------------------------------------------------------------
package salts_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	localparam logic [1:0] KIND_ACCESS     = 2'd0;
	localparam logic [1:0] KIND_INVALIDATE = 2'd1;
	localparam logic [1:0] KIND_INSTALL    = 2'd2;

	typedef struct packed {
		logic capture;
		logic read;
		logic update;
		logic clear_step;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
	} status_t;

endpackage

// ===== design/salts_ctrl.sv =====
// ---------------------------------------------------------------------------
// salts_ctrl: controller
// sequences the clearing pass after reset and the read / update of each beat
// ---------------------------------------------------------------------------
module salts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  salts_pkg::status_t status,
	output salts_pkg::cmd_t    cmd,
	output logic               busy,
	output logic               done
);
	import salts_pkg::*;

	state_t state_q, state_d;
	logic   cleared_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cleared_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_UPDATE);
			if (status.clear_done) cleared_q <= 1'b1;
		end
	end

	// result registers load at the end of the update cycle, done follows them
	assign done = done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		cmd.clear_step = !cleared_q;
		case (state_q)
			ST_IDLE: begin
				busy = !cleared_q;
				if (cleared_q && start) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.read = 1'b1;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== design/salts_dp.sv =====
// ---------------------------------------------------------------------------
// salts_dp: datapath
// set memory of tags, valid / dirty marks and recency order, plus counters
// ---------------------------------------------------------------------------
module salts_dp #(
	parameter int LINE_BYTES = 64,
	parameter int SET_COUNT  = 64,
	parameter int WAY_COUNT  = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  salts_pkg::cmd_t    cmd,
	output salts_pkg::status_t status,
	input  logic [1:0]         kind,
	input  logic [31:0]        address,
	input  logic               write_req,
	input  logic               is_fill,
	output logic               hit,
	output logic [31:0]        evict_address,
	output logic               victim_dirty,
	output logic               inval_dirty,
	output logic [31:0]        access_count,
	output logic [31:0]        hit_count,
	output logic [31:0]        miss_count,
	output logic [31:0]        write_count,
	output logic [31:0]        writeback_count
);
	import salts_pkg::*;

	localparam int OFF_W = $clog2(LINE_BYTES);
	localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int SET_B = $clog2(SET_COUNT);
	localparam int TAG_W = 32 - OFF_W - SET_B;
	localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam int ROW_W = WAY_COUNT * (TAG_W + 2 + WAY_W);

	typedef struct packed {
		logic [WAY_COUNT-1:0][TAG_W-1:0] tag;
		logic [WAY_COUNT-1:0]            valid;
		logic [WAY_COUNT-1:0]            dirty;
		logic [WAY_COUNT-1:0][WAY_W-1:0] order;
	} row_t;

	logic [ROW_W-1:0] mem [SET_COUNT];
	row_t             row_s1;
	logic [SET_W-1:0] clr_q;

	logic [1:0]       kind_q;
	logic [TAG_W-1:0] tag_q;
	logic [SET_W-1:0] set_q;
	logic             wr_q, fill_q;

	logic [31:0] acc_q, hit_q, miss_q, wrc_q, wb_q;

	// set index and tag of the captured address
	logic [31:0] line_a;
	assign line_a = address >> OFF_W;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			tag_q  <= TAG_W'(line_a >> SET_B);
			set_q  <= (SET_COUNT > 1) ? SET_W'(line_a) : '0;
			wr_q   <= write_req;
			fill_q <= is_fill;
		end
	end

	// reset row: everything clear, order 0..n-1
	row_t init_row;
	always_comb begin
		init_row = '0;
		for (int i = 0; i < WAY_COUNT; i++) init_row.order[i] = WAY_W'(i);
	end

	// lookup and victim choice over the read row
	logic             hit_w;
	logic [WAY_W-1:0] hway, vway, tway;
	logic [WAY_W-1:0] hpos, vpos, tpos;
	logic             fnd;
	always_comb begin
		hit_w = 1'b0;
		hway  = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--)
			if (row_s1.valid[w] && row_s1.tag[w] == tag_q) begin
				hit_w = 1'b1;
				hway  = WAY_W'(w);
			end
		hpos = '0;
		for (int i = WAY_COUNT - 1; i >= 0; i--)
			if (row_s1.order[i] == hway) hpos = WAY_W'(i);
		vpos = WAY_W'(WAY_COUNT - 1);
		fnd  = 1'b0;
		for (int i = 0; i < WAY_COUNT; i++)
			if (!fnd && !row_s1.valid[row_s1.order[i]]) begin
				vpos = WAY_W'(i);
				fnd  = 1'b1;
			end
		vway = row_s1.order[vpos];
		tway = hit_w ? hway : vway;
		tpos = hit_w ? hpos : vpos;
	end

	// updated row and result
	row_t             new_row;
	logic             h_o, ed_o, wd_o, do_evict, count_dem;
	logic [31:0]      ea_o;
	logic [31:0]      line_v;
	always_comb begin
		new_row  = row_s1;
		h_o      = 1'b0;
		ed_o     = 1'b0;
		wd_o     = 1'b0;
		ea_o     = '0;
		do_evict = 1'b0;
		line_v   = 32'(((64'(row_s1.tag[vway]) << SET_B) | 64'(set_q)) << OFF_W);
		case (kind_q)
			KIND_ACCESS, KIND_INSTALL: begin
				h_o = hit_w;
				if (hit_w) begin
					if (wr_q || kind_q == KIND_INSTALL) new_row.dirty[hway] = 1'b1;
				end else begin
					do_evict = row_s1.valid[vway];
					ea_o     = do_evict ? line_v : '0;
					ed_o     = do_evict && row_s1.dirty[vway];
					new_row.valid[vway] = 1'b1;
					new_row.tag[vway]   = tag_q;
					new_row.dirty[vway] = wr_q || kind_q == KIND_INSTALL;
				end
				if (kind_q == KIND_ACCESS) begin
					for (int i = 1; i < WAY_COUNT; i++)
						if (WAY_W'(i) <= tpos) new_row.order[i] = row_s1.order[i-1];
					new_row.order[0] = tway;
				end else if (!hit_w) begin
					for (int i = 0; i < WAY_COUNT - 1; i++)
						if (WAY_W'(i) >= vpos) new_row.order[i] = row_s1.order[i+1];
					new_row.order[WAY_COUNT-1] = vway;
				end
			end
			KIND_INVALIDATE: begin
				h_o = hit_w;
				if (hit_w) begin
					wd_o = row_s1.dirty[hway];
					new_row.valid[hway] = 1'b0;
					new_row.dirty[hway] = 1'b0;
					for (int i = 1; i < WAY_COUNT; i++)
						if (WAY_W'(i) <= hpos) new_row.order[i] = row_s1.order[i-1];
					new_row.order[0] = hway;
				end
			end
			default: ;
		endcase
		count_dem = kind_q == KIND_ACCESS && !fill_q;
	end

	// set memory: clearing pass, read, write back
	always_ff @(posedge clk) begin
		if (cmd.clear_step) mem[clr_q] <= ROW_W'(init_row);
		else if (cmd.update) mem[set_q] <= ROW_W'(new_row);
		if (cmd.read) row_s1 <= row_t'(mem[set_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear_step) clr_q <= clr_q + SET_W'(1);
	end
	assign status.clear_done = cmd.clear_step && (clr_q == SET_W'(SET_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; hit_q <= '0; miss_q <= '0; wrc_q <= '0; wb_q <= '0;
		end else if (cmd.update) begin
			if (count_dem) begin
				acc_q <= acc_q + 32'd1;
				if (wr_q) wrc_q <= wrc_q + 32'd1;
				if (hit_w) hit_q <= hit_q + 32'd1;
				else miss_q <= miss_q + 32'd1;
			end
			if (ed_o) wb_q <= wb_q + 32'd1;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit           <= h_o;
			evict_address <= ea_o;
			victim_dirty  <= ed_o;
			inval_dirty   <= wd_o;
		end
	end
	assign access_count    = acc_q;
	assign hit_count       = hit_q;
	assign miss_count      = miss_q;
	assign write_count     = wrc_q;
	assign writeback_count = wb_q;

endmodule

// ===== design/set_assoc_lru_tag_store_core.sv =====
// ---------------------------------------------------------------------------
// set_assoc_lru_tag_store_core: lru tag store of a write-back cache
// controller and datapath around one set memory with true lru order
// ---------------------------------------------------------------------------
// a beat is taken when start is high and busy low. the cycle after acceptance
// reads the set row from the single-port set memory, the next cycle updates
// it and registers the result, and done is high for exactly one cycle after
// that with the result; the receiver cannot stall it. busy is low again while
// done is high, so a new beat can be taken while done is high. after reset a
// clearing pass writes one set a cycle, all SET_COUNT sets, while busy stays
// high. counters on the result ports hold the values after the beat and wrap.
module set_assoc_lru_tag_store_core #(
	parameter int LINE_BYTES = 64,
	parameter int SET_COUNT  = 64,
	parameter int WAY_COUNT  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] address,
	input  logic        write_req,
	input  logic        is_fill,
	output logic        done,
	output logic        hit,
	output logic [31:0] evict_address,
	output logic        victim_dirty,
	output logic        inval_dirty,
	output logic [31:0] access_count,
	output logic [31:0] hit_count,
	output logic [31:0] miss_count,
	output logic [31:0] write_count,
	output logic [31:0] writeback_count
);
	import salts_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencing
	salts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status),
		.cmd(cmd), .busy(busy), .done(done)
	);

	// set memory, lookup, replacement and counters
	salts_dp #(
		.LINE_BYTES(LINE_BYTES), .SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.kind(kind), .address(address), .write_req(write_req), .is_fill(is_fill),
		.hit(hit), .evict_address(evict_address), .victim_dirty(victim_dirty),
		.inval_dirty(inval_dirty), .access_count(access_count), .hit_count(hit_count),
		.miss_count(miss_count), .write_count(write_count),
		.writeback_count(writeback_count)
	);

endmodule
